### hw/rtl/ngti_pkg.sv
// Shared types, constants and sizes for the nested-grid trilinear interpolator.
package ngti_pkg;

   localparam int PARENT_R  = 64;
   localparam int PARENT_TH = 64;
   localparam int PARENT_Z  = 64;
   localparam int NEST_MAX  = 64;
   localparam int FRAC_BITS = 16;

   localparam int GRID_CELLS = PARENT_R * PARENT_TH * PARENT_Z;
   localparam int ADDR_W     = $clog2(GRID_CELLS);
   localparam int RW         = $clog2(PARENT_R);
   localparam int TW         = $clog2(PARENT_TH);
   localparam int ZW         = $clog2(PARENT_Z);

   // Coordinate is formed in Q.17 and then moved to Q.FRAC_BITS.
   localparam int UP_SH = (FRAC_BITS >= 17) ? FRAC_BITS - 17 : 0;
   localparam int DN_SH = (FRAC_BITS < 17) ? 17 - FRAC_BITS : 0;
   localparam int P17_W = 28;
   localparam int POS_W = P17_W + UP_SH;

   localparam int VAL_W  = 64;
   localparam int HALF_W = 32;
   localparam int PROD_W = HALF_W + POS_W;
   localparam int FULL_W = VAL_W + POS_W;

   localparam int CSR_AW = 5;
   localparam logic [2:0] CSR_CENTER_R   = 3'd0;
   localparam logic [2:0] CSR_CENTER_TH  = 3'd1;
   localparam logic [2:0] CSR_CENTER_Z   = 3'd2;
   localparam logic [2:0] CSR_INV_REF    = 3'd3;
   localparam logic [2:0] CSR_NEST_SZ_R  = 3'd4;
   localparam logic [2:0] CSR_NEST_SZ_TH = 3'd5;
   localparam logic [2:0] CSR_NEST_SZ_Z  = 3'd6;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_INTERP = 1'b1;

   localparam logic [1:0] AXIS_R  = 2'd0;
   localparam logic [1:0] AXIS_TH = 2'd1;
   localparam logic [1:0] AXIS_Z  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP,
      ST_READ,
      ST_LAST,
      ST_DIFF,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC,
      ST_DONE
   } state_type;

endpackage

### hw/rtl/nested_grid_trilinear_interp_unit.sv
// Top level of the nested-grid trilinear interpolator: grid store, mapping and blend sequencer.
//
//  channel   ports                          handshake
//  request   start, busy, req_*             accepted when start and not busy
//  result    rsp_valid, rsp_*               one-cycle strobe, cannot be held off
//  config    psel, penable, pwrite, paddr   APB-style, pready always high
//
// A sample write goes to the grid in the cycle it is accepted and busy stays low. A query
// keeps busy high through axis mapping, corner reads from the single grid port, 7 blends of
// difference, low multiply, high multiply and accumulate on the shared 32-bit multiplier,
// and saturation; the result strobe comes in the first cycle with busy low again.
// Reset is synchronous and clears the sequencer, configuration registers and result strobe; the grid is not cleared.
module nested_grid_trilinear_interp_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic [5:0]         req_parent_r,
   input  logic [5:0]         req_parent_th,
   input  logic [5:0]         req_parent_z,
   input  logic signed [31:0] req_sample,
   input  logic [5:0]         req_nest_r,
   input  logic [5:0]         req_nest_th,
   input  logic [5:0]         req_nest_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_interpolated_value,
   output logic               rsp_saturated,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ngti_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Configuration registers.
   logic [5:0]  center_r_ff, center_th_ff, center_z_ff;
   logic [16:0] inv_ref_ff;
   logic [6:0]  nsz_r_ff, nsz_th_ff, nsz_z_ff;
   logic [2:0]  csr_idx;
   logic        csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_r_ff  <= 6'd0;
         center_th_ff <= 6'd0;
         center_z_ff  <= 6'd0;
         inv_ref_ff   <= 17'd65536;
         nsz_r_ff     <= 7'd64;
         nsz_th_ff    <= 7'd64;
         nsz_z_ff     <= 7'd64;
      end else if (csr_wr) begin
         unique case (csr_idx)
            ngti_pkg::CSR_CENTER_R:   center_r_ff  <= pwdata[5:0];
            ngti_pkg::CSR_CENTER_TH:  center_th_ff <= pwdata[5:0];
            ngti_pkg::CSR_CENTER_Z:   center_z_ff  <= pwdata[5:0];
            ngti_pkg::CSR_INV_REF:    inv_ref_ff   <= pwdata[16:0];
            ngti_pkg::CSR_NEST_SZ_R:  nsz_r_ff     <= pwdata[6:0];
            ngti_pkg::CSR_NEST_SZ_TH: nsz_th_ff    <= pwdata[6:0];
            ngti_pkg::CSR_NEST_SZ_Z:  nsz_z_ff     <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         ngti_pkg::CSR_CENTER_R:   prdata = {26'd0, center_r_ff};
         ngti_pkg::CSR_CENTER_TH:  prdata = {26'd0, center_th_ff};
         ngti_pkg::CSR_CENTER_Z:   prdata = {26'd0, center_z_ff};
         ngti_pkg::CSR_INV_REF:    prdata = {15'd0, inv_ref_ff};
         ngti_pkg::CSR_NEST_SZ_R:  prdata = {25'd0, nsz_r_ff};
         ngti_pkg::CSR_NEST_SZ_TH: prdata = {25'd0, nsz_th_ff};
         ngti_pkg::CSR_NEST_SZ_Z:  prdata = {25'd0, nsz_z_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   // Sequencer state.
   ngti_pkg::state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rd_pend_ff;
   logic       accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != ngti_pkg::ST_IDLE);

   // Latched query indices.
   logic [5:0] nest_r_ff, nest_th_ff, nest_z_ff;

   always_ff @(posedge clock) begin
      if (accept && req_operation == ngti_pkg::OP_INTERP) begin
         nest_r_ff  <= req_nest_r;
         nest_th_ff <= req_nest_th;
         nest_z_ff  <= req_nest_z;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ngti_pkg::ST_IDLE: begin
            if (accept && req_operation == ngti_pkg::OP_INTERP) begin
               state_in = ngti_pkg::ST_MAP;
               axis_in  = ngti_pkg::AXIS_R;
            end
         end
         ngti_pkg::ST_MAP: begin
            axis_in = axis_ff + 2'd1;
            if (axis_ff == ngti_pkg::AXIS_Z) begin
               state_in = ngti_pkg::ST_READ;
               cnt_in   = 3'd0;
            end
         end
         ngti_pkg::ST_READ: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = ngti_pkg::ST_LAST;
            end
         end
         ngti_pkg::ST_LAST: begin
            state_in = ngti_pkg::ST_DIFF;
            cnt_in   = 3'd0;
         end
         ngti_pkg::ST_DIFF:   state_in = ngti_pkg::ST_MUL_LO;
         ngti_pkg::ST_MUL_LO: state_in = ngti_pkg::ST_MUL_HI;
         ngti_pkg::ST_MUL_HI: state_in = ngti_pkg::ST_ACC;
         ngti_pkg::ST_ACC: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) begin
               state_in = ngti_pkg::ST_DONE;
            end else begin
               state_in = ngti_pkg::ST_DIFF;
            end
         end
         ngti_pkg::ST_DONE: state_in = ngti_pkg::ST_IDLE;
         default:           state_in = ngti_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ngti_pkg::ST_IDLE;
         axis_ff    <= 2'd0;
         cnt_ff     <= 3'd0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         axis_ff    <= axis_in;
         cnt_ff     <= cnt_in;
         rd_pend_ff <= (state_ff == ngti_pkg::ST_READ);
      end
   end

   // Axis mapping: one axis per cycle.
   logic [5:0]  map_center, map_idx;
   logic [6:0]  map_size, map_sz;
   logic signed [8:0]  map_d;
   logic signed [ngti_pkg::P17_W-1:0] map_p17;
   logic signed [ngti_pkg::POS_W-1:0] map_pos, map_base, map_base_c, map_frac;
   logic signed [ngti_pkg::POS_W-1:0] map_hi_lim;
   logic [ngti_pkg::RW-1:0] r0_ff;
   logic [ngti_pkg::TW-1:0] t0_ff;
   logic [ngti_pkg::ZW-1:0] z0_ff;
   logic signed [ngti_pkg::POS_W-1:0] fr_ff, ft_ff, fz_ff;

   always_comb begin
      unique case (axis_ff)
         ngti_pkg::AXIS_R: begin
            map_center = center_r_ff;
            map_size   = nsz_r_ff;
            map_idx    = nest_r_ff;
            map_hi_lim = ngti_pkg::POS_W'(ngti_pkg::PARENT_R - 2);
         end
         ngti_pkg::AXIS_TH: begin
            map_center = center_th_ff;
            map_size   = nsz_th_ff;
            map_idx    = nest_th_ff;
            map_hi_lim = ngti_pkg::POS_W'(ngti_pkg::PARENT_TH - 2);
         end
         default: begin
            map_center = center_z_ff;
            map_size   = nsz_z_ff;
            map_idx    = nest_z_ff;
            map_hi_lim = ngti_pkg::POS_W'(ngti_pkg::PARENT_Z - 2);
         end
      endcase
      map_sz = (32'(map_size) > ngti_pkg::NEST_MAX) ? 7'(ngti_pkg::NEST_MAX) : map_size;
      map_d  = $signed({2'b00, map_idx, 1'b0}) - $signed({2'b00, map_sz});
      map_p17 = $signed({5'd0, map_center, 17'd0})
              + ngti_pkg::P17_W'(map_d * $signed({1'b0, inv_ref_ff}));
      map_pos  = (ngti_pkg::POS_W'(map_p17) <<< ngti_pkg::UP_SH) >>> ngti_pkg::DN_SH;
      map_base = map_pos >>> ngti_pkg::FRAC_BITS;
      if (map_base > map_hi_lim) begin
         map_base_c = map_hi_lim;
      end else if (map_base < 0) begin
         map_base_c = '0;
      end else begin
         map_base_c = map_base;
      end
      map_frac = map_pos - (map_base_c <<< ngti_pkg::FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ngti_pkg::ST_MAP) begin
         unique case (axis_ff)
            ngti_pkg::AXIS_R: begin
               r0_ff <= map_base_c[ngti_pkg::RW-1:0];
               fr_ff <= map_frac;
            end
            ngti_pkg::AXIS_TH: begin
               t0_ff <= map_base_c[ngti_pkg::TW-1:0];
               ft_ff <= map_frac;
            end
            default: begin
               z0_ff <= map_base_c[ngti_pkg::ZW-1:0];
               fz_ff <= map_frac;
            end
         endcase
      end
   end

   // Grid memory port.
   logic                       ram_we;
   logic [ngti_pkg::ADDR_W-1:0] ram_addr;
   logic [31:0]                ram_rdata;
   logic [ngti_pkg::RW-1:0]    rd_r;
   logic [ngti_pkg::TW-1:0]    rd_t;
   logic [ngti_pkg::ZW-1:0]    rd_z;
   logic                       wr_ok;

   always_comb begin
      wr_ok = (32'(req_parent_r) < ngti_pkg::PARENT_R)
           && (32'(req_parent_th) < ngti_pkg::PARENT_TH)
           && (32'(req_parent_z) < ngti_pkg::PARENT_Z);
      rd_r = r0_ff + ngti_pkg::RW'(cnt_ff[2]);
      rd_t = t0_ff + ngti_pkg::TW'(cnt_ff[1]);
      rd_z = z0_ff + ngti_pkg::ZW'(cnt_ff[0]);
      ram_we = 1'b0;
      if (state_ff == ngti_pkg::ST_READ) begin
         ram_addr = ngti_pkg::ADDR_W'((32'(rd_r) * ngti_pkg::PARENT_TH + 32'(rd_t))
                    * ngti_pkg::PARENT_Z + 32'(rd_z));
      end else begin
         ram_we   = accept && (req_operation == ngti_pkg::OP_WRITE) && wr_ok;
         ram_addr = ngti_pkg::ADDR_W'((32'(req_parent_r) * ngti_pkg::PARENT_TH
                    + 32'(req_parent_th)) * ngti_pkg::PARENT_Z + 32'(req_parent_z));
      end
   end

   ngti_ram #(
      .WIDTH(32),
      .DEPTH(ngti_pkg::GRID_CELLS)
   ) u_grid (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(req_sample),
      .rdata(ram_rdata)
   );

   // Operand queue: corners shift in, each blend takes the two at the head.
   logic signed [ngti_pkg::VAL_W-1:0] q_ff [8];
   logic signed [ngti_pkg::VAL_W-1:0] q_in [8];
   logic [ngti_pkg::HALF_W*2-1:0]     dmag_ff;
   logic                              neg_ff;
   logic [ngti_pkg::POS_W-1:0]        fmag_ff;
   logic [ngti_pkg::PROD_W-1:0]       plo_ff, phi_ff;
   logic signed [ngti_pkg::VAL_W:0]   ld_d;
   logic signed [ngti_pkg::POS_W-1:0] ld_f;
   logic [ngti_pkg::HALF_W-1:0]       mul_a;
   logic [ngti_pkg::PROD_W-1:0]       mul_p;
   logic [ngti_pkg::FULL_W-1:0]       acc_p;
   logic [ngti_pkg::VAL_W-1:0]        acc_m;
   logic signed [ngti_pkg::VAL_W-1:0] acc_res;

   always_comb begin
      if (cnt_ff < 3'd4) begin
         ld_f = fz_ff;
      end else if (cnt_ff < 3'd6) begin
         ld_f = ft_ff;
      end else begin
         ld_f = fr_ff;
      end
      ld_d  = $signed({q_ff[1][ngti_pkg::VAL_W-1], q_ff[1]})
            - $signed({q_ff[0][ngti_pkg::VAL_W-1], q_ff[0]});
      // Shared multiplier: low half of the difference first, then the high half.
      mul_a = (state_ff == ngti_pkg::ST_MUL_HI) ? dmag_ff[63:32] : dmag_ff[31:0];
      mul_p = ngti_pkg::PROD_W'(mul_a) * ngti_pkg::PROD_W'(fmag_ff);
      acc_p = (ngti_pkg::FULL_W'(phi_ff) << ngti_pkg::HALF_W) + ngti_pkg::FULL_W'(plo_ff)
            + (ngti_pkg::FULL_W'(1) << (ngti_pkg::FRAC_BITS - 1));
      acc_m   = ngti_pkg::VAL_W'(acc_p >> ngti_pkg::FRAC_BITS);
      acc_res = neg_ff ? q_ff[0] - $signed(acc_m) : q_ff[0] + $signed(acc_m);
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         q_in[k] = q_ff[k];
      end
      if (rd_pend_ff) begin
         for (int k = 0; k < 7; k++) begin
            q_in[k] = q_ff[k+1];
         end
         q_in[7] = ngti_pkg::VAL_W'($signed(ram_rdata));
      end else if (state_ff == ngti_pkg::ST_ACC) begin
         for (int k = 0; k < 6; k++) begin
            q_in[k] = q_ff[k+2];
         end
         q_in[3'(3'd6 - cnt_ff)] = acc_res;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 8; k++) begin
         q_ff[k] <= q_in[k];
      end
      if (state_ff == ngti_pkg::ST_DIFF) begin
         dmag_ff <= ld_d[ngti_pkg::VAL_W] ? ngti_pkg::VAL_W'(-ld_d)
                                          : ngti_pkg::VAL_W'(ld_d);
         fmag_ff <= ld_f[ngti_pkg::POS_W-1] ? ngti_pkg::POS_W'(-ld_f)
                                            : ngti_pkg::POS_W'(ld_f);
         neg_ff  <= ld_d[ngti_pkg::VAL_W] != ld_f[ngti_pkg::POS_W-1];
      end
      if (state_ff == ngti_pkg::ST_MUL_LO) begin
         plo_ff <= mul_p;
      end
      if (state_ff == ngti_pkg::ST_MUL_HI) begin
         phi_ff <= mul_p;
      end
   end

   // Result register with saturation to 32 bits.
   logic        rsp_valid_ff;
   logic signed [31:0] rsp_val_ff;
   logic        rsp_sat_ff;
   logic signed [ngti_pkg::VAL_W-1:0] fin_v;

   assign fin_v = q_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ngti_pkg::ST_DONE);
      end
      if (state_ff == ngti_pkg::ST_DONE) begin
         if (fin_v > 64'sd2147483647) begin
            rsp_val_ff <= 32'sh7FFFFFFF;
            rsp_sat_ff <= 1'b1;
         end else if (fin_v < -64'sd2147483648) begin
            rsp_val_ff <= 32'sh80000000;
            rsp_sat_ff <= 1'b1;
         end else begin
            rsp_val_ff <= fin_v[31:0];
            rsp_sat_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_interpolated_value = rsp_val_ff;
   assign rsp_saturated          = rsp_sat_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ngti_pkg::ST_DONE |=> rsp_valid)
      else $error("finished query produced no result");
   a_no_wr_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !busy)
      else $error("grid write while a query runs");
   a_blend_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ngti_pkg::ST_ACC |-> cnt_ff <= 3'd6)
      else $error("blend counter past last blend");

endmodule

### hw/rtl/ngti_ram.sv
// Generic single-port RAM with registered read data.
module ngti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
